[sv/amd_pkg.sv]
package amd_pkg;

	// Event commands
	localparam logic [1:0] CMD_PRESS   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_POLL    = 2'd2;

	// Gap classes, also used as the resolved-gap level
	localparam logic [1:0] GAP_INTRA = 2'd0;
	localparam logic [1:0] GAP_CHAR  = 2'd1;
	localparam logic [1:0] GAP_WORD  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_GLITCH_FLOOR = 2'd0;
	localparam logic [1:0] REG_DOT_FLOOR    = 2'd1;
	localparam logic [1:0] REG_DOT_CEILING  = 2'd2;

	// Reset values
	localparam logic [7:0] GLITCH_RESET    = 8'd12;
	localparam logic [9:0] DOT_FLOOR_RESET = 10'd20;
	localparam logic [9:0] DOT_CEIL_RESET  = 10'd500;
	localparam logic [9:0] DOT_RESET       = 10'd80;

	// Element code: leading one marks the length
	localparam logic [6:0] CODE_EMPTY = 7'h01;

	localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
	localparam logic [6:0] CHAR_SPACE   = 7'h20;

	typedef struct packed {
		logic [7:0] glitch_floor;
		logic [9:0] dot_floor;
		logic [9:0] dot_ceiling;
	} cfg_t;

	// Up to two result words caused by one event
	typedef struct packed {
		logic [1:0] count;
		logic [6:0] char0;
		logic [6:0] char1;
		logic [9:0] dot;
	} result_pair_t;

	// Leading-one element code to ASCII; unknown codes give '?'
	function automatic logic [6:0] glyph(input logic [6:0] code);
		logic [6:0] c;
		c = CHAR_UNKNOWN;
		if (!code[6]) begin
			unique case (code[5:0])
				6'd2:  c = 7'h45; // E
				6'd3:  c = 7'h54; // T
				6'd4:  c = 7'h49; // I
				6'd5:  c = 7'h41; // A
				6'd6:  c = 7'h4E; // N
				6'd7:  c = 7'h4D; // M
				6'd8:  c = 7'h53; // S
				6'd9:  c = 7'h55; // U
				6'd10: c = 7'h52; // R
				6'd11: c = 7'h57; // W
				6'd12: c = 7'h44; // D
				6'd13: c = 7'h4B; // K
				6'd14: c = 7'h47; // G
				6'd15: c = 7'h4F; // O
				6'd16: c = 7'h48; // H
				6'd17: c = 7'h56; // V
				6'd18: c = 7'h46; // F
				6'd20: c = 7'h4C; // L
				6'd22: c = 7'h50; // P
				6'd23: c = 7'h4A; // J
				6'd24: c = 7'h42; // B
				6'd25: c = 7'h58; // X
				6'd26: c = 7'h43; // C
				6'd27: c = 7'h59; // Y
				6'd28: c = 7'h5A; // Z
				6'd29: c = 7'h51; // Q
				6'd32: c = 7'h35; // 5
				6'd33: c = 7'h34; // 4
				6'd35: c = 7'h33; // 3
				6'd39: c = 7'h32; // 2
				6'd47: c = 7'h31; // 1
				6'd48: c = 7'h36; // 6
				6'd56: c = 7'h37; // 7
				6'd60: c = 7'h38; // 8
				6'd62: c = 7'h39; // 9
				6'd63: c = 7'h30; // 0
				default: c = CHAR_UNKNOWN;
			endcase
		end
		return c;
	endfunction

endpackage

[sv/amd_event_if.sv]
interface amd_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] time_ms;

	modport source(output valid, cmd, time_ms, input ready);
	modport sink(input valid, cmd, time_ms, output ready);
endinterface

[sv/amd_result_if.sv]
interface amd_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last;
	logic [9:0] dot_estimate;

	modport source(output valid, char_code, last, dot_estimate, input ready);
	modport sink(input valid, char_code, last, dot_estimate, output ready);
endinterface

[sv/amd_decode_core.sv]
module amd_decode_core
	import amd_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [1:0]           cmd,
	input  logic [TIME_BITS-1:0] now,
	input  cfg_t                 cfg,
	output result_pair_t         res
);

	logic [9:0]           dot_len_q;
	logic [6:0]           code_q;
	logic                 key_held_q;
	logic                 rel_pend_q;
	logic [TIME_BITS-1:0] mark_start_q;
	logic [TIME_BITS-1:0] rel_start_q;
	logic [1:0]           gap_level_q;

	logic [TIME_BITS-1:0] gap, mark;
	logic [TIME_BITS-1:0] dot2_w, dot5_w, glitch_w;
	logic                 gap_glitch, gap_le2, gap_le5;
	logic [1:0]           kind;
	logic                 jg_char, jg_space, jg_letter;
	logic [1:0]           jg_level;
	logic                 mark_ok, dash;
	logic signed [12:0]   diff, quarter, nxt;
	logic [9:0]           dot_new;
	logic                 do_judge;

	logic [9:0]           dot_len_d;
	logic [6:0]           code_d;
	logic                 key_held_d, rel_pend_d;
	logic [TIME_BITS-1:0] mark_start_d, rel_start_d;
	logic [1:0]           gap_level_d;

	// Elapsed times, wrapping at the timestamp width
	assign gap  = now - rel_start_q;
	assign mark = now - mark_start_q;

	assign dot2_w   = TIME_BITS'({dot_len_q, 1'b0});
	assign dot5_w   = TIME_BITS'({1'b0, dot_len_q, 2'b00}) + TIME_BITS'(dot_len_q);
	assign glitch_w = TIME_BITS'(cfg.glitch_floor);

	// Sort the gap
	assign gap_glitch = gap < glitch_w;
	assign gap_le2    = gap <= dot2_w;
	assign gap_le5    = gap <= dot5_w;
	assign kind       = gap_le2 ? GAP_INTRA : (gap_le5 ? GAP_CHAR : GAP_WORD);

	// Each gap level fires once per idle period
	always_comb begin
		jg_char  = (kind != GAP_INTRA) && (gap_level_q == GAP_INTRA);
		jg_letter = jg_char && (code_q != CODE_EMPTY);
		jg_level = jg_char ? GAP_CHAR : gap_level_q;
		jg_space = (kind == GAP_WORD) && (jg_level != GAP_WORD);
		if (jg_space)
			jg_level = GAP_WORD;
	end

	// Mark classification and dot estimate update
	assign mark_ok = mark >= glitch_w;
	assign dash    = mark > dot2_w;

	always_comb begin
		diff    = $signed({2'b00, mark[10:0]}) - $signed({3'b000, dot_len_q});
		quarter = diff[12] ? ((diff + 13'sd3) >>> 2) : (diff >>> 2);
		nxt     = $signed({3'b000, dot_len_q}) + quarter;
		if (nxt < $signed({3'b000, cfg.dot_floor}))
			nxt = $signed({3'b000, cfg.dot_floor});
		if (nxt > $signed({3'b000, cfg.dot_ceiling}))
			nxt = $signed({3'b000, cfg.dot_ceiling});
		dot_new = nxt[9:0];
	end

	// Next state per command
	always_comb begin
		dot_len_d    = dot_len_q;
		code_d       = code_q;
		key_held_d   = key_held_q;
		rel_pend_d   = rel_pend_q;
		mark_start_d = mark_start_q;
		rel_start_d  = rel_start_q;
		gap_level_d  = gap_level_q;
		do_judge     = 1'b0;
		case (cmd)
			CMD_PRESS: begin
				if (rel_pend_q && gap_glitch) begin
					rel_pend_d = 1'b0;
					key_held_d = 1'b1;
				end else begin
					do_judge     = rel_pend_q;
					if (jg_letter && rel_pend_q)
						code_d = CODE_EMPTY;
					rel_pend_d   = 1'b0;
					gap_level_d  = GAP_INTRA;
					mark_start_d = now;
					key_held_d   = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (mark_ok) begin
					if (!dash)
						dot_len_d = dot_new;
					if (!code_q[6])
						code_d = {code_q[5:0], dash};
					rel_start_d = now;
					rel_pend_d  = 1'b1;
					key_held_d  = 1'b0;
				end
			end
			CMD_POLL: begin
				if (rel_pend_q && !key_held_q) begin
					do_judge    = 1'b1;
					gap_level_d = jg_level;
					if (jg_letter)
						code_d = CODE_EMPTY;
				end
			end
			default: ;
		endcase
	end

	// Results: letter first, then space
	always_comb begin
		res.dot   = dot_len_q;
		res.char0 = jg_letter ? glyph(code_q) : CHAR_SPACE;
		res.char1 = CHAR_SPACE;
		res.count = 2'd0;
		if (do_judge)
			res.count = 2'({1'b0, jg_letter} + {1'b0, jg_space});
	end

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_len_q    <= DOT_RESET;
			code_q       <= CODE_EMPTY;
			key_held_q   <= 1'b0;
			rel_pend_q   <= 1'b0;
			mark_start_q <= '0;
			rel_start_q  <= '0;
			gap_level_q  <= GAP_WORD;
		end else if (fire) begin
			dot_len_q    <= dot_len_d;
			code_q       <= code_d;
			key_held_q   <= key_held_d;
			rel_pend_q   <= rel_pend_d;
			mark_start_q <= mark_start_d;
			rel_start_q  <= rel_start_d;
			gap_level_q  <= gap_level_d;
		end
	end

endmodule

[sv/amd_result_buf.sv]
module amd_result_buf
	import amd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  result_pair_t        pair,
	output logic                free,
	amd_result_if.source        res
);

	logic [1:0] rem_q;
	logic [6:0] char0_q;
	logic [6:0] char1_q;
	logic [9:0] dot_q;
	logic       pop;

	assign res.valid        = rem_q != 2'd0;
	assign res.char_code    = char0_q;
	assign res.last         = rem_q == 2'd1;
	assign res.dot_estimate = dot_q;

	assign pop  = res.valid && res.ready;
	// Room for a new pair once the final word leaves
	assign free = (rem_q == 2'd0) || ((rem_q == 2'd1) && res.ready);

	// Load a new pair or advance to the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= pair.count;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char0_q <= pair.char0;
			char1_q <= pair.char1;
			dot_q   <= pair.dot;
		end else if (pop) begin
			char0_q <= char1_q;
		end
	end

endmodule

[sv/adaptive_morse_decoder.sv]
// Adaptive Morse decoder.
// evt carries key events: cmd (0 key pressed, 1 key released, 2 poll tick,
// 3 ignored) with a millisecond timestamp time_ms. res carries decoded
// characters: a letter, digit or '?' when a character gap is seen, and a
// space on a word gap, each with the dot estimate and a last flag that marks
// the final word caused by one event. A key-down or poll yields 0 to 2 words.
// The user must write settings via cfg_we/cfg_index/cfg_data only while
// idle (not enforced): 0 glitch floor, 1 dot floor, 2 dot ceiling.
// Timing: an event is registered on acceptance and then decoded by one pass
// of compare/add logic into a two-word result register, which offers the
// first word. One event is taken every cycle while res is ready and events
// give at most one word; an event that gives a letter and a space holds the
// result register until both words have left.
// When res is stalled, the registered event waits until the result register
// frees up, and evt.ready drops; nothing is lost.
// Reset clears the decoder to dot estimate 80 ms, an empty element code,
// key up and word gap resolved, and restores the register defaults.
module adaptive_morse_decoder
	import amd_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [9:0]   cfg_data,
	amd_event_if.sink    evt,
	amd_result_if.source res
);

	cfg_t                 cfg_q;
	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 buf_free;
	logic                 fire;
	result_pair_t         pair;

	assign fire      = valid_s1 && buf_free;
	assign evt.ready = !valid_s1 || fire;

	// Settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glitch_floor <= GLITCH_RESET;
			cfg_q.dot_floor    <= DOT_FLOOR_RESET;
			cfg_q.dot_ceiling  <= DOT_CEIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLITCH_FLOOR: cfg_q.glitch_floor <= cfg_data[7:0];
				REG_DOT_FLOOR:    cfg_q.dot_floor    <= cfg_data;
				REG_DOT_CEILING:  cfg_q.dot_ceiling  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: take an event whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			cmd_s1  <= evt.cmd;
			time_s1 <= TIME_BITS'(evt.time_ms);
		end
	end

	amd_decode_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.now    (time_s1),
		.cfg    (cfg_q),
		.res    (pair)
	);

	amd_result_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.pair   (pair),
		.free   (buf_free),
		.res    (res)
	);

endmodule

[dv/tb.sv]
module tb;
	import amd_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam logic [6:0] CODE_FULL   = 7'h40;
	localparam int         STALL_LIMIT = 2000;
	localparam int         SETTLE      = 8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] time_ms;
	} key_event_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
		logic [9:0] dot_estimate;
	} decoded_char_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	// Block inputs, known from time zero
	logic        ev_valid  = 1'b0;
	logic [1:0]  ev_cmd    = CMD_PRESS;
	logic [31:0] ev_time   = '0;
	logic        res_ready = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_GLITCH_FLOOR;
	logic [9:0]  cfg_data  = '0;

	amd_event_if  evt();
	amd_result_if res();

	assign evt.valid   = ev_valid;
	assign evt.cmd     = ev_cmd;
	assign evt.time_ms = ev_time;
	assign res.ready   = res_ready;

	adaptive_morse_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.res       (res)
	);

	// Decoder settings as the block holds them
	logic [7:0] glitch_floor = GLITCH_RESET;
	logic [9:0] dot_floor    = DOT_FLOOR_RESET;
	logic [9:0] dot_ceiling  = DOT_CEIL_RESET;

	// Decoder state
	logic [9:0]  dot_len      = DOT_RESET;
	logic [6:0]  element_code = CODE_EMPTY;
	logic        key_held     = 1'b0;
	logic        rel_pending  = 1'b0;
	logic [31:0] mark_start   = '0;
	logic [31:0] rel_start    = '0;
	logic [1:0]  gap_level    = GAP_WORD;

	// Leading-one code to character, '?' where no character is assigned
	string glyph_map = "??ETIANMSURWDKGOHVF?L?PJBXCYZQ??54?3???2???????16???????7???8?90";

	key_event_t    event_q[$];
	decoded_char_t char_q[$];
	logic [6:0]    gap_chars[$];

	key_event_t    next_event;
	decoded_char_t seen, want;
	int            src_gap     = 0;
	int            snk_gap     = 0;
	int            idle_cycles = 0;
	int            n_errors    = 0;
	int            n_pushed    = 0;
	bit            bursts_on   = 1'b1;
	logic [31:0]   clock_ms    = '0;

	function automatic logic [6:0] glyph_for(input logic [6:0] code);
		byte ch;
		if (code[6])
			return CHAR_UNKNOWN;
		ch = glyph_map.getc(int'(code[5:0]));
		return ch[6:0];
	endfunction

	// Move the dot estimate a quarter of the way toward a dot, then clamp
	task automatic track_dot(input logic [31:0] sample);
		int cur, nxt;
		cur = int'(dot_len);
		nxt = cur + (int'(sample) - cur) / 4;
		if (nxt < int'(dot_floor))
			nxt = int'(dot_floor);
		if (nxt > int'(dot_ceiling))
			nxt = int'(dot_ceiling);
		dot_len = nxt[9:0];
	endtask

	// Classify a gap; each gap level fires once per idle period
	task automatic sort_gap(input logic [31:0] gap);
		logic [33:0] two_dots, five_dots;
		logic [1:0]  kind;
		two_dots  = {23'd0, dot_len, 1'b0};
		five_dots = 34'(dot_len) * 34'd5;
		if (gap <= two_dots)
			kind = GAP_INTRA;
		else if (gap <= five_dots)
			kind = GAP_CHAR;
		else
			kind = GAP_WORD;
		if (kind != GAP_INTRA && gap_level == GAP_INTRA) begin
			if (element_code != CODE_EMPTY) begin
				gap_chars.push_back(glyph_for(element_code));
				element_code = CODE_EMPTY;
			end
			gap_level = GAP_CHAR;
		end
		if (kind == GAP_WORD && gap_level != GAP_WORD) begin
			gap_chars.push_back(CHAR_SPACE);
			gap_level = GAP_WORD;
		end
	endtask

	// Advance the decoder by one event and queue the characters it yields
	task automatic decode_event(input logic [1:0] cmd, input logic [31:0] t);
		logic [31:0]   span;
		logic          dash;
		decoded_char_t out_char;
		gap_chars.delete();
		case (cmd)
			CMD_PRESS: begin
				span = t - rel_start;
				if (rel_pending && span < {24'd0, glitch_floor}) begin
					// bounce in the gap: resume the mark in progress
					rel_pending = 1'b0;
					key_held    = 1'b1;
				end else begin
					if (rel_pending)
						sort_gap(span);
					rel_pending = 1'b0;
					gap_level   = GAP_INTRA;
					mark_start  = t;
					key_held    = 1'b1;
				end
			end
			CMD_RELEASE: begin
				span = t - mark_start;
				if (span >= {24'd0, glitch_floor}) begin
					dash = span > {21'd0, dot_len, 1'b0};
					if (!dash)
						track_dot(span);
					if (element_code < CODE_FULL)
						element_code = {element_code[5:0], dash};
					rel_start   = t;
					rel_pending = 1'b1;
					key_held    = 1'b0;
				end
			end
			CMD_POLL: begin
				if (rel_pending && !key_held)
					sort_gap(t - rel_start);
			end
			default: ;
		endcase
		foreach (gap_chars[i]) begin
			out_char.char_code    = gap_chars[i];
			out_char.last         = (i == gap_chars.size() - 1);
			out_char.dot_estimate = dot_len;
			char_q.push_back(out_char);
		end
	endtask

	// Event driver: present queued events, idle in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (ev_valid && evt.ready)
				decode_event(ev_cmd, ev_time);
			if (!ev_valid || evt.ready) begin
				if (src_gap != 0) begin
					src_gap  <= src_gap - 1;
					ev_valid <= 1'b0;
				end else if (event_q.size() != 0 && bursts_on && $urandom_range(0, 9) == 0) begin
					src_gap  <= $urandom_range(0, 18);
					ev_valid <= 1'b0;
				end else if (event_q.size() != 0) begin
					next_event = event_q.pop_front();
					ev_valid <= 1'b1;
					ev_cmd   <= next_event.cmd;
					ev_time  <= next_event.time_ms;
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each word against the oldest expected character
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			snk_gap   <= 0;
		end else begin
			if (res.valid && res_ready) begin
				seen.char_code    = res.char_code;
				seen.last         = res.last;
				seen.dot_estimate = res.dot_estimate;
				if (char_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected word: expected none, got %h/%b/%0d",
						$time, seen.char_code, seen.last, seen.dot_estimate);
				end else begin
					want = char_q.pop_front();
					if (seen !== want) begin
						n_errors++;
						$display("%0t: mismatch (char/last/dot): expected %h/%b/%0d, got %h/%b/%0d",
							$time, want.char_code, want.last, want.dot_estimate,
							seen.char_code, seen.last, seen.dot_estimate);
					end
				end
			end
			// stall the result side in bursts
			if (snk_gap != 0) begin
				snk_gap   <= snk_gap - 1;
				res_ready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 11) == 0) begin
				snk_gap   <= $urandom_range(0, 18);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((ev_valid && evt.ready) || (res.valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("** adaptive_morse_decoder: FAILED **");
				$finish;
			end
		end
	end

	task automatic add_event(input logic [1:0] cmd, input logic [31:0] t);
		key_event_t e;
		e.cmd     = cmd;
		e.time_ms = t;
		event_q.push_back(e);
		n_pushed++;
	endtask

	function automatic int jitter(input int unit);
		return int'($urandom_range(0, unit / 4)) - unit / 8;
	endfunction

	task automatic key_mark(input bit dash, input int unit);
		int len;
		len = (dash ? 3 * unit : unit) + jitter(unit);
		add_event(CMD_PRESS, clock_ms);
		clock_ms += len;
		add_event(CMD_RELEASE, clock_ms);
	endtask

	// Key up for some dot units, polling somewhere inside now and then
	task automatic key_gap(input int units, input int unit);
		int len;
		len = units * unit + jitter(unit);
		if ($urandom_range(0, 2) == 0)
			add_event(CMD_POLL, clock_ms + $urandom_range(0, len));
		clock_ms += len;
	endtask

	task automatic key_letter(input int n, input logic [7:0] pat, input int unit);
		for (int i = 0; i < n; i++) begin
			key_mark(pat[i], unit);
			if (i < n - 1)
				key_gap(1, unit);
		end
	endtask

	task automatic key_word(input int unit);
		int nl, n;
		nl = $urandom_range(1, 5);
		for (int l = 0; l < nl; l++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 6);
			key_letter(n, 8'($urandom), unit);
			if (l < nl - 1)
				key_gap(3, unit);
		end
		key_gap(3, unit);
		key_gap(4, unit);
	endtask

	// Broken keying: stray events, bounces, repeated edges, long silence
	task automatic key_noise();
		int r;
		r = $urandom_range(0, 200);
		case ($urandom_range(0, 4))
			0: add_event(2'($urandom_range(0, 3)), $urandom);
			1: begin
				add_event(CMD_PRESS, clock_ms);
				clock_ms += $urandom_range(0, glitch_floor + 2);
				add_event(CMD_RELEASE, clock_ms);
			end
			2: begin
				add_event(CMD_RELEASE, clock_ms);
				clock_ms += $urandom_range(0, glitch_floor + 2);
				add_event(CMD_PRESS, clock_ms);
				clock_ms += $urandom_range(1, 300);
				add_event(CMD_RELEASE, clock_ms);
			end
			3: begin
				add_event(CMD_PRESS, clock_ms);
				add_event(CMD_PRESS, clock_ms + r);
				add_event(CMD_RELEASE, clock_ms + 2 * r);
				add_event(CMD_RELEASE, clock_ms + 3 * r);
				clock_ms += 3 * r;
			end
			default: begin
				clock_ms += $urandom;
				add_event(CMD_POLL, clock_ms);
			end
		endcase
		clock_ms += $urandom_range(0, 500);
	endtask

	task automatic run_traffic(input int n, input int unit_lo, input int unit_hi);
		int goal;
		goal = n_pushed + n;
		while (n_pushed < goal) begin
			if ($urandom_range(0, 6) == 0)
				key_noise();
			else
				key_word($urandom_range(unit_lo, unit_hi));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GLITCH_FLOOR: glitch_floor = data[7:0];
			REG_DOT_FLOOR:    dot_floor    = data;
			REG_DOT_CEILING:  dot_ceiling  = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [9:0] g, input logic [9:0] f, input logic [9:0] c);
		write_reg(REG_GLITCH_FLOOR, g);
		write_reg(REG_DOT_FLOOR, f);
		write_reg(REG_DOT_CEILING, c);
		@(negedge clk);
	endtask

	// Wait until every event is taken and every character has arrived
	task automatic drain();
		do
			@(negedge clk);
		while (event_q.size() != 0 || ev_valid || char_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed keying at the reset settings
		add_event(CMD_UNUSED, 32'hFFFF_FFFF);
		add_event(CMD_POLL, 32'd5);          // nothing pending
		add_event(CMD_RELEASE, 32'd100);     // key up since reset: mark runs from zero
		add_event(CMD_POLL, 32'd300);        // character gap
		add_event(CMD_POLL, 32'd1200);       // word gap
		add_event(CMD_POLL, 32'd1300);       // already resolved
		clock_ms = 32'd2000;
		key_letter(1, 8'h01, 80);
		key_gap(3, 80);
		key_letter(7, 8'h00, 80);            // more than six elements
		key_gap(7, 80);
		add_event(CMD_PRESS, clock_ms);
		add_event(CMD_PRESS, clock_ms + 400);    // restart the mark
		add_event(CMD_RELEASE, clock_ms + 460);
		add_event(CMD_RELEASE, clock_ms + 700);  // measured from the restart
		add_event(CMD_PRESS, clock_ms + 705);    // bounce in the gap
		add_event(CMD_RELEASE, clock_ms + 800);
		clock_ms += 2000;
		add_event(CMD_PRESS, clock_ms);
		add_event(CMD_RELEASE, clock_ms + 4);    // bounce on the mark
		add_event(CMD_RELEASE, clock_ms + 32'hF000_0000);
		add_event(CMD_PRESS, 32'hFFFF_FFFF);
		drain();

		// Widest limits, no bounce filter, time wrapping early
		write_reg(REG_UNUSED, 10'h3FF);
		configure(10'd0, 10'd1, 10'd1023);
		clock_ms = 32'hFFFF_F000;
		run_traffic(180, 5, 120);
		drain();

		// Heaviest bounce filter
		configure(10'd255, 10'd300, 10'd1023);
		run_traffic(80, 260, 600);
		drain();

		// Floor above ceiling: the ceiling wins
		configure(10'd0, 10'd1023, 10'd1);
		run_traffic(80, 20, 100);
		drain();

		// Random settings
		for (int p = 0; p < 3; p++) begin
			configure({2'($urandom), (p == 0) ? 8'd0 : 8'($urandom_range(0, 40))},
				10'($urandom_range(20, 100)), 10'($urandom_range(150, 1023)));
			run_traffic(100, 15, 250);
			drain();
		end

		// Closing stretch at full rate
		bursts_on = 1'b0;
		configure(10'd8, 10'd10, 10'd900);
		run_traffic(120, 20, 200);
		drain();

		if (n_errors == 0)
			$display("** adaptive_morse_decoder: PASSED **");
		else
			$display("** adaptive_morse_decoder: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/amd_pkg.sv
sv/amd_event_if.sv
sv/amd_result_if.sv
sv/amd_decode_core.sv
sv/amd_result_buf.sv
sv/adaptive_morse_decoder.sv
dv/tb.sv
